// ===== rtl/ptma_pkg.sv =====
// Shared types and constants for the particle transfer matrix aperture unit.
package ptma_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 3;

    // Width of the inverse half-aperture registers.
    localparam int APERTURE_W = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_POS_ROW = 3'd0,
        CFG_X_ANG_ROW = 3'd1,
        CFG_Y_POS_ROW = 3'd2,
        CFG_Y_ANG_ROW = 3'd3,
        CFG_INV_AP_X  = 3'd4,
        CFG_INV_AP_Y  = 3'd5
    } cfg_reg_t;

    // Per-stage load enables of the pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

endpackage

// ===== rtl/particle_transfer_matrix_aperture_unit.sv =====
// Top level: linear transfer map per plane followed by an elliptical aperture cut.
// From request acceptance to result valid, products, rounded sums, aperture scaling,
// squares and the final compare each take one register stage.
// Throughput is one request per cycle; each stage holds only while the stage after it
// is full and stalled, so bubbles close up. Reset (aresetn low, synchronous) empties
// the pipeline and returns the rows to the identity map and both apertures to no limit.
module particle_transfer_matrix_aperture_unit import ptma_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [3*COEF_WIDTH-1:0]       cfg_wr_data,
    // Input channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_x_pos_in,
    input  logic signed [COORD_WIDTH-1:0] s_x_ang_in,
    input  logic signed [COORD_WIDTH-1:0] s_y_pos_in,
    input  logic signed [COORD_WIDTH-1:0] s_y_ang_in,
    input  logic signed [COORD_WIDTH-1:0] s_momentum_dev,
    input  logic                          s_alive_in,
    // Result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_x_pos_out,
    output logic signed [COORD_WIDTH-1:0] m_x_ang_out,
    output logic signed [COORD_WIDTH-1:0] m_y_pos_out,
    output logic signed [COORD_WIDTH-1:0] m_y_ang_out,
    output logic                          m_alive_out
);

    localparam int RW = 3 * COEF_WIDTH;
    localparam logic [RW-1:0] POS_ROW_RESET = RW'(1) << (COEF_WIDTH - 6);
    localparam logic [RW-1:0] ANG_ROW_RESET = RW'(1) << (2 * COEF_WIDTH - 6);

    logic [RW-1:0]         x_pos_row_reg, x_ang_row_reg, y_pos_row_reg, y_ang_row_reg;
    logic [APERTURE_W-1:0] inv_ap_x_reg, inv_ap_y_reg;

    stage_en_t en;
    logic      v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic      alive1_reg, alive2_reg;

    logic signed [COORD_WIDTH-1:0] x_pos2, x_ang2, y_pos2, y_ang2;
    logic signed [COORD_WIDTH-1:0] x_pos3_reg, x_ang3_reg, y_pos3_reg, y_ang3_reg;
    logic signed [COORD_WIDTH-1:0] x_pos4_reg, x_ang4_reg, y_pos4_reg, y_ang4_reg;
    logic signed [COORD_WIDTH-1:0] x_pos5_reg, x_ang5_reg, y_pos5_reg, y_ang5_reg;

    // Configuration registers; writes must arrive only while the pipeline is empty, which the block does not enforce.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_pos_row_reg <= POS_ROW_RESET;
            x_ang_row_reg <= ANG_ROW_RESET;
            y_pos_row_reg <= POS_ROW_RESET;
            y_ang_row_reg <= ANG_ROW_RESET;
            inv_ap_x_reg  <= '0;
            inv_ap_y_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                CFG_X_POS_ROW: x_pos_row_reg <= cfg_wr_data;
                CFG_X_ANG_ROW: x_ang_row_reg <= cfg_wr_data;
                CFG_Y_POS_ROW: y_pos_row_reg <= cfg_wr_data;
                CFG_Y_ANG_ROW: y_ang_row_reg <= cfg_wr_data;
                CFG_INV_AP_X:  inv_ap_x_reg  <= cfg_wr_data[APERTURE_W-1:0];
                CFG_INV_AP_Y:  inv_ap_y_reg  <= cfg_wr_data[APERTURE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A stage loads when it is empty or when the stage after it moves on.
    assign en.s5   = !v5_reg || m_ready;
    assign en.s4   = !v4_reg || en.s5;
    assign en.s3   = !v3_reg || en.s4;
    assign en.s2   = !v2_reg || en.s3;
    assign en.s1   = !v1_reg || en.s2;
    assign s_ready = en.s1;

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en.s1) begin
                v1_reg <= s_valid;
            end
            if (en.s2) begin
                v2_reg <= v1_reg;
            end
            if (en.s3) begin
                v3_reg <= v2_reg;
            end
            if (en.s4) begin
                v4_reg <= v3_reg;
            end
            if (en.s5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Alive flag for the first two stages.
    always_ff @(posedge aclk) begin
        if (en.s1) begin
            alive1_reg <= s_alive_in;
        end
        if (en.s2) begin
            alive2_reg <= alive1_reg;
        end
    end

    // The four rows of the transfer map.
    ptma_affine #(
        .COORD_WIDTH(COORD_WIDTH),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_x_pos (
        .aclk    (aclk),
        .en      (en),
        .row     (x_pos_row_reg),
        .a0      (s_x_pos_in),
        .a1      (s_x_ang_in),
        .a2      (s_momentum_dev),
        .pass_val(s_x_pos_in),
        .alive_s1(alive1_reg),
        .result  (x_pos2)
    );

    ptma_affine #(
        .COORD_WIDTH(COORD_WIDTH),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_x_ang (
        .aclk    (aclk),
        .en      (en),
        .row     (x_ang_row_reg),
        .a0      (s_x_pos_in),
        .a1      (s_x_ang_in),
        .a2      (s_momentum_dev),
        .pass_val(s_x_ang_in),
        .alive_s1(alive1_reg),
        .result  (x_ang2)
    );

    ptma_affine #(
        .COORD_WIDTH(COORD_WIDTH),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_y_pos (
        .aclk    (aclk),
        .en      (en),
        .row     (y_pos_row_reg),
        .a0      (s_y_pos_in),
        .a1      (s_y_ang_in),
        .a2      (s_momentum_dev),
        .pass_val(s_y_pos_in),
        .alive_s1(alive1_reg),
        .result  (y_pos2)
    );

    ptma_affine #(
        .COORD_WIDTH(COORD_WIDTH),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_y_ang (
        .aclk    (aclk),
        .en      (en),
        .row     (y_ang_row_reg),
        .a0      (s_y_pos_in),
        .a1      (s_y_ang_in),
        .a2      (s_momentum_dev),
        .pass_val(s_y_ang_in),
        .alive_s1(alive1_reg),
        .result  (y_ang2)
    );

    // Coordinates ride along while the aperture test runs.
    always_ff @(posedge aclk) begin
        if (en.s3) begin
            x_pos3_reg <= x_pos2;
            x_ang3_reg <= x_ang2;
            y_pos3_reg <= y_pos2;
            y_ang3_reg <= y_ang2;
        end
        if (en.s4) begin
            x_pos4_reg <= x_pos3_reg;
            x_ang4_reg <= x_ang3_reg;
            y_pos4_reg <= y_pos3_reg;
            y_ang4_reg <= y_ang3_reg;
        end
        if (en.s5) begin
            x_pos5_reg <= x_pos4_reg;
            x_ang5_reg <= x_ang4_reg;
            y_pos5_reg <= y_pos4_reg;
            y_ang5_reg <= y_ang4_reg;
        end
    end

    // Aperture cut on the transformed positions.
    ptma_aperture #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_aperture (
        .aclk     (aclk),
        .en       (en),
        .x_pos    (x_pos2),
        .y_pos    (y_pos2),
        .inv_x    (inv_ap_x_reg),
        .inv_y    (inv_ap_y_reg),
        .alive_s2 (alive2_reg),
        .alive_out(m_alive_out)
    );

    // Result channel.
    assign m_valid     = v5_reg;
    assign m_x_pos_out = x_pos5_reg;
    assign m_x_ang_out = x_ang5_reg;
    assign m_y_pos_out = y_pos5_reg;
    assign m_y_ang_out = y_ang5_reg;

endmodule

// ===== rtl/ptma_affine.sv =====
// One row of the transfer map: three products, rounded sum and saturation.
module ptma_affine import ptma_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 20
) (
    input  logic                          aclk,
    input  stage_en_t                     en,
    input  logic [3*COEF_WIDTH-1:0]       row,
    input  logic signed [COORD_WIDTH-1:0] a0,
    input  logic signed [COORD_WIDTH-1:0] a1,
    input  logic signed [COORD_WIDTH-1:0] a2,
    input  logic signed [COORD_WIDTH-1:0] pass_val,
    input  logic                          alive_s1,
    output logic signed [COORD_WIDTH-1:0] result
);

    localparam int PW   = COORD_WIDTH + COEF_WIDTH;
    localparam int SW   = PW + 2;
    localparam int FRAC = COEF_WIDTH - 6;

    localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) << (FRAC - 1);
    localparam logic signed [SW-1:0] MAX_VAL =
        {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] MIN_VAL = ~MAX_VAL;

    logic signed [COEF_WIDTH-1:0]  c0, c1, c2;
    logic signed [PW-1:0]          prod0_next, prod1_next, prod2_next;
    logic signed [PW-1:0]          prod0_reg, prod1_reg, prod2_reg;
    logic signed [COORD_WIDTH-1:0] pass_reg;
    logic signed [SW-1:0]          sum;
    logic signed [SW-1:0]          shifted;
    logic signed [COORD_WIDTH-1:0] result_next, result_reg;

    // Unpack the three signed coefficients of the row.
    assign c0 = signed'(row[COEF_WIDTH-1:0]);
    assign c1 = signed'(row[2*COEF_WIDTH-1:COEF_WIDTH]);
    assign c2 = signed'(row[3*COEF_WIDTH-1:2*COEF_WIDTH]);

    // Stage 1: the three full-precision products.
    assign prod0_next = PW'(a0) * PW'(c0);
    assign prod1_next = PW'(a1) * PW'(c1);
    assign prod2_next = PW'(a2) * PW'(c2);

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            prod0_reg <= prod0_next;
            prod1_reg <= prod1_next;
            prod2_reg <= prod2_next;
            pass_reg  <= pass_val;
        end
    end

    // Stage 2: exact sum, round half up, saturate; dead particles pass unchanged.
    assign sum     = SW'(prod0_reg) + SW'(prod1_reg) + SW'(prod2_reg) + ROUND_HALF;
    assign shifted = sum >>> FRAC;

    always_comb begin
        if (!alive_s1) begin
            result_next = pass_reg;
        end else if (shifted > MAX_VAL) begin
            result_next = MAX_VAL[COORD_WIDTH-1:0];
        end else if (shifted < MIN_VAL) begin
            result_next = MIN_VAL[COORD_WIDTH-1:0];
        end else begin
            result_next = shifted[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/ptma_aperture.sv =====
// Elliptical aperture test on the transformed positions, three stages deep.
module ptma_aperture import ptma_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  stage_en_t                     en,
    input  logic signed [COORD_WIDTH-1:0] x_pos,
    input  logic signed [COORD_WIDTH-1:0] y_pos,
    input  logic [APERTURE_W-1:0]         inv_x,
    input  logic [APERTURE_W-1:0]         inv_y,
    input  logic                          alive_s2,
    output logic                          alive_out
);

    localparam int PW = COORD_WIDTH + APERTURE_W;
    localparam int UW = APERTURE_W + 1;
    localparam int QW = 2 * UW;

    logic [COORD_WIDTH-1:0] mag_x, mag_y;
    logic [PW-1:0]          px_next, py_next, px_reg, py_reg;
    logic                   alive3_reg;
    logic                   over_x, over_y;
    logic [UW-1:0]          ux, uy;
    logic [QW-1:0]          u2_next, v2_next, u2_reg, v2_reg;
    logic                   ok4_reg;
    logic [QW:0]            radius_sum;
    logic                   alive5_next, alive5_reg;

    // Stage 3: scale each magnitude by its inverse half-aperture.
    assign mag_x   = x_pos[COORD_WIDTH-1] ? COORD_WIDTH'(-x_pos) : COORD_WIDTH'(x_pos);
    assign mag_y   = y_pos[COORD_WIDTH-1] ? COORD_WIDTH'(-y_pos) : COORD_WIDTH'(y_pos);
    assign px_next = PW'(mag_x) * PW'(inv_x);
    assign py_next = PW'(mag_y) * PW'(inv_y);

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            alive3_reg <= alive_s2;
        end
    end

    // Stage 4: anything above one unit is out; otherwise square the scaled values.
    assign over_x  = (|px_reg[PW-1:UW]) || (px_reg[UW-1] && (|px_reg[UW-2:0]));
    assign over_y  = (|py_reg[PW-1:UW]) || (py_reg[UW-1] && (|py_reg[UW-2:0]));
    assign ux      = px_reg[UW-1:0];
    assign uy      = py_reg[UW-1:0];
    assign u2_next = QW'(ux) * QW'(ux);
    assign v2_next = QW'(uy) * QW'(uy);

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            u2_reg  <= u2_next;
            v2_reg  <= v2_next;
            ok4_reg <= alive3_reg && !over_x && !over_y;
        end
    end

    // Stage 5: inside when the sum of squares does not exceed one; the edge counts.
    assign radius_sum  = (QW+1)'(u2_reg) + (QW+1)'(v2_reg);
    assign alive5_next = ok4_reg && (radius_sum <= ((QW+1)'(1) << (2 * APERTURE_W)));

    always_ff @(posedge aclk) begin
        if (en.s5) begin
            alive5_reg <= alive5_next;
        end
    end

    assign alive_out = alive5_reg;

endmodule
